// ===== hdl/cfe2e_pkg.sv =====
// Package for the CAN frame end-to-end checker.
// Holds the transfer payload types, status codes, check constants and the CRC-8 function.
// Depends on nothing.
`default_nettype none

package cfe2e_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int STAT_BITS      = 32;

    localparam logic [3:0] DLC_FRAME  = 4'd8;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_POLY   = 8'h1D;
    localparam logic [7:0] CRC_XOROUT = 8'hFF;
    localparam logic [7:0] IGN_MAX    = 8'd1;
    localparam logic [7:0] GEAR_MAX   = 8'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_CRC      = 3'd2,
        ST_SEQUENCE = 3'd3,
        ST_VALUE    = 3'd4
    } status_t;

    typedef struct packed {
        logic [3:0] frame_length;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
        logic [7:0] byte5;
        logic [7:0] byte6;
        logic [7:0] byte7;
    } in_item_t;

    typedef struct packed {
        status_t                  status;
        logic signed [15:0]       target_speed;
        logic signed [15:0]       target_yaw_rate;
        logic                     ignition;
        logic [1:0]               gear;
        logic [3:0]               alive_value;
        logic [STAT_BITS-1:0]     length_error_count;
        logic [STAT_BITS-1:0]     crc_error_count;
        logic [STAT_BITS-1:0]     value_error_count;
        logic [STAT_BITS-1:0]     sequence_error_count;
        logic [STAT_BITS-1:0]     accepted_count;
    } out_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] target_speed;
        logic signed [15:0] target_yaw_rate;
        logic               ignition;
        logic [1:0]         gear;
        logic [3:0]         alive_value;
    } dec_t;

    typedef struct packed {
        logic len;
        logic crc;
        logic val;
        logic seq;
        logic acc;
    } bump_t;

    typedef struct packed {
        dec_t       dec;
        bump_t      bump;
        logic       load_alive;
        logic [3:0] alive;
    } check_res_t;

    // one byte through CRC-8 SAE J1850, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cfe2e_sat_cnt.sv =====
// Saturating statistics counter of the CAN frame end-to-end checker.
// Reports the low STAT_BITS bits. Depends on cfe2e_pkg.
`default_nettype none

module cfe2e_sat_cnt
    import cfe2e_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 inc,
    output logic [STAT_BITS-1:0]      count
);

    logic [COUNT_BITS-1:0]           cnt_reg;
    logic [COUNT_BITS-1:0]           cnt_next;
    logic [COUNT_BITS+STAT_BITS-1:0] cnt_ext;

    always_comb begin
        cnt_next = cnt_reg;
        if (inc && (cnt_reg != {COUNT_BITS{1'b1}})) begin
            cnt_next = cnt_reg + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt_ext = {{STAT_BITS{1'b0}}, cnt_reg};
    assign count   = cnt_ext[STAT_BITS-1:0];

`ifndef SYNTHESIS
    a_saturate_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == {COUNT_BITS{1'b1}} |=> cnt_reg == {COUNT_BITS{1'b1}})
        else $error("saturated counter moved");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !inc |=> cnt_reg == $past(cnt_reg))
        else $error("counter moved without increment");

    a_step_one: assert property (@(posedge aclk) disable iff (!aresetn)
        inc && cnt_reg != {COUNT_BITS{1'b1}} |=> cnt_reg == $past(cnt_reg) + COUNT_BITS'(1))
        else $error("counter did not step by one");
`endif

endmodule

`default_nettype wire

// ===== hdl/cfe2e_check.sv =====
// Frame checks of the CAN frame end-to-end checker: length, CRC-8, alive counter, ranges.
// Purely combinational; depends on cfe2e_pkg.
`default_nettype none

module cfe2e_check
    import cfe2e_pkg::*;
(
    input  wire in_item_t   item,
    input  wire logic       seq_seen,
    input  wire logic [3:0] prev_alive,
    output check_res_t      res
);

    logic [7:0] bytes [7];
    logic [7:0] crc_calc;
    logic [3:0] alive;
    logic [3:0] alive_exp;

    assign bytes[0] = item.byte0;
    assign bytes[1] = item.byte1;
    assign bytes[2] = item.byte2;
    assign bytes[3] = item.byte3;
    assign bytes[4] = item.byte4;
    assign bytes[5] = item.byte5;
    assign bytes[6] = item.byte6;

    always_comb begin
        logic [7:0] c;
        c = CRC_INIT;
        for (int i = 0; i < 7; i++) begin
            c = crc8_byte(c, bytes[i]);
        end
        crc_calc = c ^ CRC_XOROUT;
    end

    assign alive     = item.byte6[3:0];
    assign alive_exp = prev_alive + 4'd1;

    always_comb begin
        res            = '0;
        res.dec.status = ST_OK;
        res.alive      = alive;
        if (item.frame_length != DLC_FRAME) begin
            res.dec.status = ST_LENGTH;
            res.bump.len   = 1'b1;
        end else if (crc_calc != item.byte7) begin
            res.dec.status = ST_CRC;
            res.bump.crc   = 1'b1;
        end else if (item.byte6[7:4] != 4'd0) begin
            res.dec.status = ST_VALUE;
            res.bump.val   = 1'b1;
        end else if (seq_seen && (alive != alive_exp)) begin
            res.dec.status = ST_SEQUENCE;
            res.bump.seq   = 1'b1;
            res.load_alive = 1'b1;
        end else begin
            res.load_alive = 1'b1;
            if ((item.byte4 > IGN_MAX) || (item.byte5 > GEAR_MAX)) begin
                res.dec.status = ST_VALUE;
                res.bump.val   = 1'b1;
            end else begin
                res.dec.target_speed    = signed'({item.byte1, item.byte0});
                res.dec.target_yaw_rate = signed'({item.byte3, item.byte2});
                res.dec.ignition        = item.byte4[0];
                res.dec.gear            = item.byte5[1:0];
                res.dec.alive_value     = alive;
                res.bump.acc            = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/can_frame_e2e_checker.sv =====
// CAN frame end-to-end checker: input register, check logic, result register.
// Depends on cfe2e_pkg, cfe2e_check and cfe2e_sat_cnt.
//
// Usage:
//   s_ channel: one received frame per transfer (length code plus eight bytes).
//   m_ channel: one result per frame, in order: status, decoded fields (zero
//   unless status is ok) and the five statistics counters as they stand after
//   that frame.
//   A frame taken into the input register is checked there, then its result is registered.
//   Throughput: one frame per cycle while m_ready is high; the input register and the
//   result register form a two-stage pipeline, so a frame is taken while a result
//   waits. The whole check is combinational logic, the CRC being a flat XOR tree
//   over bytes 0 to 6.
//   Reset (aresetn low at a clock edge) empties both stages, clears the
//   alive-counter reference and all statistics counters.
//   When m_ready is low the result and counters hold; the input register
//   still takes one frame, then s_ready drops until the result is taken.
`default_nettype none

module can_frame_e2e_checker
    import cfe2e_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    in_item_t   s1_reg;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    dec_t       dec_reg;
    logic       seq_seen_reg;
    logic       seq_seen_next;
    logic [3:0] prev_alive_reg;
    logic [3:0] prev_alive_next;

    logic       advance;
    logic       s_take;
    check_res_t res;

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    cfe2e_check u_check (
        .item       (s1_reg),
        .seq_seen   (seq_seen_reg),
        .prev_alive (prev_alive_reg),
        .res        (res)
    );

    always_comb begin
        s1_valid_next   = s_take || (s1_valid_reg && !advance);
        m_valid_next    = advance || (m_valid_reg && !m_ready);
        seq_seen_next   = seq_seen_reg;
        prev_alive_next = prev_alive_reg;
        if (advance && res.load_alive) begin
            seq_seen_next   = 1'b1;
            prev_alive_next = res.alive;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            seq_seen_reg   <= 1'b0;
            prev_alive_reg <= '0;
        end else begin
            s1_valid_reg   <= s1_valid_next;
            m_valid_reg    <= m_valid_next;
            seq_seen_reg   <= seq_seen_next;
            prev_alive_reg <= prev_alive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            s1_reg <= s_data;
        end
        if (advance) begin
            dec_reg <= res.dec;
        end
    end

    // counters only move on advance, which is when the result register loads
    cfe2e_sat_cnt #(.COUNT_BITS(COUNT_BITS)) u_len_cnt (
        .aclk(aclk), .aresetn(aresetn), .inc(advance && res.bump.len),
        .count(m_data.length_error_count)
    );
    cfe2e_sat_cnt #(.COUNT_BITS(COUNT_BITS)) u_crc_cnt (
        .aclk(aclk), .aresetn(aresetn), .inc(advance && res.bump.crc),
        .count(m_data.crc_error_count)
    );
    cfe2e_sat_cnt #(.COUNT_BITS(COUNT_BITS)) u_val_cnt (
        .aclk(aclk), .aresetn(aresetn), .inc(advance && res.bump.val),
        .count(m_data.value_error_count)
    );
    cfe2e_sat_cnt #(.COUNT_BITS(COUNT_BITS)) u_seq_cnt (
        .aclk(aclk), .aresetn(aresetn), .inc(advance && res.bump.seq),
        .count(m_data.sequence_error_count)
    );
    cfe2e_sat_cnt #(.COUNT_BITS(COUNT_BITS)) u_acc_cnt (
        .aclk(aclk), .aresetn(aresetn), .inc(advance && res.bump.acc),
        .count(m_data.accepted_count)
    );

    assign m_valid                = m_valid_reg;
    assign m_data.status          = dec_reg.status;
    assign m_data.target_speed    = dec_reg.target_speed;
    assign m_data.target_yaw_rate = dec_reg.target_yaw_rate;
    assign m_data.ignition        = dec_reg.ignition;
    assign m_data.gear            = dec_reg.gear;
    assign m_data.alive_value     = dec_reg.alive_value;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s1_valid_reg)
        else $error("pipeline not empty after reset");

    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |->
        m_data.target_speed == '0 && m_data.target_yaw_rate == '0 &&
        m_data.ignition == 1'b0 && m_data.gear == 2'd0 && m_data.alive_value == 4'd0)
        else $error("decoded fields nonzero on rejected frame");

    a_ok_gear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_OK |-> m_data.gear != 2'd3)
        else $error("accepted frame with out-of-range gear");

    a_stall_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data.accepted_count) &&
        $stable(m_data.length_error_count) && $stable(m_data.crc_error_count))
        else $error("statistics moved while result stalled");

    a_ok_bumps: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.dec.status == ST_OK |-> res.load_alive && res.bump.acc)
        else $error("accepted frame did not update sequence and count");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for can_frame_e2e_checker: directed and random CAN frames sent over the s_/m_
// handshakes, each result checked field by field against a predictor of the frame checks.
// Depends on cfe2e_pkg and the can_frame_e2e_checker RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cfe2e_pkg::*;

    typedef struct {
        in_item_t frame;
        int       gap;
        bit       drain;
    } pending_frame_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      m_ready = 1'b0;
    in_item_t  s_data  = '0;
    logic      s_ready;
    logic      m_valid;
    out_item_t m_data;

    pending_frame_t frames_to_send[$];
    out_item_t      want_results[$];
    out_item_t      want;

    // predictor state
    logic                 seq_seen  = 1'b0;
    logic [3:0]           ref_alive = 4'd0;
    logic [STAT_BITS-1:0] n_len = '0, n_crc = '0, n_val = '0, n_seq = '0, n_ok = '0;

    // generator view of the alive counter reference
    logic [3:0] gen_alive = 4'd0;
    bit         gen_seen  = 1'b0;

    int err_count    = 0;
    int in_count     = 0;
    int rx_count     = 0;
    int total_frames = 0;
    int gap_left     = 0;
    int hold_left    = 0;
    int ready_roll   = 0;
    bit in_fire      = 1'b0;
    bit long_hold_done = 1'b0;

    can_frame_e2e_checker DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] j1850_crc(input in_item_t f);
        logic [55:0] msg;
        logic [7:0]  c;
        msg = {f.byte0, f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6};
        c = CRC_INIT;
        for (int i = 0; i < 7; i++) begin
            c = c ^ msg[55 - 8*i -: 8];
            for (int k = 0; k < 8; k++) begin
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
            end
        end
        return c ^ CRC_XOROUT;
    endfunction

    function automatic logic [STAT_BITS-1:0] sat_inc(input logic [STAT_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic out_item_t decode_frame(input in_item_t f);
        out_item_t r;
        r = '0;
        r.status = ST_OK;
        if (f.frame_length != DLC_FRAME) begin
            n_len = sat_inc(n_len);
            r.status = ST_LENGTH;
        end else if (j1850_crc(f) != f.byte7) begin
            n_crc = sat_inc(n_crc);
            r.status = ST_CRC;
        end else if (f.byte6[7:4] != 4'd0) begin
            n_val = sat_inc(n_val);
            r.status = ST_VALUE;
        end else if (seq_seen && f.byte6[3:0] != 4'(ref_alive + 4'd1)) begin
            ref_alive = f.byte6[3:0];
            n_seq = sat_inc(n_seq);
            r.status = ST_SEQUENCE;
        end else begin
            seq_seen  = 1'b1;
            ref_alive = f.byte6[3:0];
            if (f.byte4 > IGN_MAX || f.byte5 > GEAR_MAX) begin
                n_val = sat_inc(n_val);
                r.status = ST_VALUE;
            end else begin
                r.target_speed    = {f.byte1, f.byte0};
                r.target_yaw_rate = {f.byte3, f.byte2};
                r.ignition        = f.byte4[0];
                r.gear            = f.byte5[1:0];
                r.alive_value     = f.byte6[3:0];
                n_ok = sat_inc(n_ok);
            end
        end
        r.length_error_count   = n_len;
        r.crc_error_count      = n_crc;
        r.value_error_count    = n_val;
        r.sequence_error_count = n_seq;
        r.accepted_count       = n_ok;
        return r;
    endfunction

    function automatic in_item_t make_frame(input logic [3:0] len, input logic [15:0] spd,
            input logic [15:0] yaw, input logic [7:0] ign, input logic [7:0] gear,
            input logic [7:0] b6, input logic [7:0] flip);
        in_item_t f;
        f.frame_length   = len;
        {f.byte1, f.byte0} = spd;
        {f.byte3, f.byte2} = yaw;
        f.byte4 = ign;
        f.byte5 = gear;
        f.byte6 = b6;
        f.byte7 = 8'h00;
        f.byte7 = j1850_crc(f) ^ flip;
        return f;
    endfunction

    function automatic void queue_frame(input in_item_t f, input bit drain);
        pending_frame_t p;
        int             r;
        p.frame = f;
        p.drain = drain;
        r = $urandom_range(0, 99);
        if (frames_to_send.size() >= 700 && frames_to_send.size() < 900) begin
            p.gap = 0;
        end else if (r < 55) begin
            p.gap = 0;
        end else if (r < 90) begin
            p.gap = $urandom_range(1, 3);
        end else begin
            p.gap = $urandom_range(8, 40);
        end
        frames_to_send.push_back(p);
        if (f.frame_length == DLC_FRAME && j1850_crc(f) == f.byte7 && f.byte6[7:4] == 4'd0) begin
            gen_alive = f.byte6[3:0];
            gen_seen  = 1'b1;
        end
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] got,
            input logic [31:0] want_v);
        if (err_count < 50) begin
            $display("mismatch %s: got %h want %h (result %0d)", field, got, want_v, rx_count);
        end
        err_count++;
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (frames_to_send.size() != 0 &&
                         !(frames_to_send[0].drain && want_results.size() != 0)) begin
                s_valid  <= 1'b1;
                s_data   <= frames_to_send[0].frame;
                gap_left = frames_to_send[0].gap;
                void'(frames_to_send.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && rx_count >= 400) begin
            long_hold_done = 1'b1;
            hold_left      = 300;
            m_ready <= 1'b0;
        end else if (rx_count >= 800 && rx_count < 1000) begin
            m_ready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 65) begin
                m_ready <= 1'b1;
            end else if (ready_roll < 92) begin
                hold_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                hold_left = $urandom_range(8, 40);
                m_ready <= 1'b0;
            end
        end
    end

    // monitor: predict on input transfer, check on result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                rx_count++;
                if (want_results.size() == 0) begin
                    $display("unexpected result transfer %0d", rx_count);
                    err_count++;
                end else begin
                    want = want_results.pop_front();
                    if (m_data.status !== want.status)
                        note_mismatch("status", 32'(m_data.status), 32'(want.status));
                    if (m_data.target_speed !== want.target_speed)
                        note_mismatch("target_speed", 32'(m_data.target_speed),
                                      32'(want.target_speed));
                    if (m_data.target_yaw_rate !== want.target_yaw_rate)
                        note_mismatch("target_yaw_rate", 32'(m_data.target_yaw_rate),
                                      32'(want.target_yaw_rate));
                    if (m_data.ignition !== want.ignition)
                        note_mismatch("ignition", 32'(m_data.ignition), 32'(want.ignition));
                    if (m_data.gear !== want.gear)
                        note_mismatch("gear", 32'(m_data.gear), 32'(want.gear));
                    if (m_data.alive_value !== want.alive_value)
                        note_mismatch("alive_value", 32'(m_data.alive_value),
                                      32'(want.alive_value));
                    if (m_data.length_error_count !== want.length_error_count)
                        note_mismatch("length_error_count", m_data.length_error_count,
                                      want.length_error_count);
                    if (m_data.crc_error_count !== want.crc_error_count)
                        note_mismatch("crc_error_count", m_data.crc_error_count,
                                      want.crc_error_count);
                    if (m_data.value_error_count !== want.value_error_count)
                        note_mismatch("value_error_count", m_data.value_error_count,
                                      want.value_error_count);
                    if (m_data.sequence_error_count !== want.sequence_error_count)
                        note_mismatch("sequence_error_count", m_data.sequence_error_count,
                                      want.sequence_error_count);
                    if (m_data.accepted_count !== want.accepted_count)
                        note_mismatch("accepted_count", m_data.accepted_count,
                                      want.accepted_count);
                end
            end
            if (s_valid && s_ready) begin
                want_results.push_back(decode_frame(s_data));
                in_count++;
            end
        end
    end

    initial begin
        int          r;
        logic [3:0]  len;
        logic [3:0]  alive;
        logic [7:0]  ign;
        logic [7:0]  gear;
        logic [7:0]  b6;
        logic [7:0]  flip;
        logic [95:0] noise;
        in_item_t    f;

        // errors before the first good frame, then the sequence reference
        queue_frame(make_frame(4'd0, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'h00, 8'h00), 1'b0);
        queue_frame(make_frame(4'd15, 16'hFFFF, 16'hFFFF, 8'd1, 8'd2, 8'h03, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h1234, 16'h5678, 8'd1, 8'd1, 8'hF3, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h8000, 16'h7FFF, 8'd1, 8'd2, 8'h05, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h7FFF, 16'h8000, 8'd0, 8'd0, 8'h06, 8'h00), 1'b0);
        // bad CRC, then high nibble set: reference stays at 6
        queue_frame(make_frame(DLC_FRAME, 16'h0102, 16'h0304, 8'd0, 8'd1, 8'h07, 8'h01), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h0102, 16'h0304, 8'd0, 8'd1, 8'h07, 8'h80), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h0102, 16'h0304, 8'd0, 8'd1, 8'h17, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h0102, 16'h0304, 8'd0, 8'd1, 8'h07, 8'h00), 1'b0);
        // skipped counter resyncs
        queue_frame(make_frame(DLC_FRAME, 16'hAAAA, 16'h5555, 8'd1, 8'd0, 8'h09, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h5555, 16'hAAAA, 8'd1, 8'd0, 8'h0A, 8'h00), 1'b0);
        // range errors still move the reference
        queue_frame(make_frame(DLC_FRAME, 16'h0001, 16'h0001, 8'd2, 8'd0, 8'h0B, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h0001, 16'h0001, 8'd0, 8'd3, 8'h0C, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h0001, 16'h0001, 8'hFF, 8'hFF, 8'h0D, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'h0E, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'hFFFF, 16'hFFFF, 8'd1, 8'd2, 8'h0F, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h00FF, 16'hFF00, 8'd0, 8'd2, 8'h00, 8'h00), 1'b0);
        queue_frame(make_frame(4'd7, 16'h1111, 16'h2222, 8'd0, 8'd0, 8'h01, 8'h00), 1'b0);
        queue_frame(make_frame(4'd9, 16'h1111, 16'h2222, 8'd0, 8'd0, 8'h01, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h1111, 16'h2222, 8'd0, 8'd0, 8'h01, 8'h00), 1'b0);
        // repeated counter
        queue_frame(make_frame(DLC_FRAME, 16'h1111, 16'h2222, 8'd0, 8'd0, 8'h01, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00), 1'b0);
        queue_frame(make_frame(DLC_FRAME, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'h02, 8'hFF), 1'b0);

        for (int i = 0; i < 1530; i++) begin
            r     = $urandom_range(0, 99);
            alive = gen_seen ? 4'(gen_alive + 4'd1) : 4'($urandom_range(0, 15));
            len   = DLC_FRAME;
            ign   = 8'($urandom_range(0, 1));
            gear  = 8'($urandom_range(0, 2));
            b6    = {4'd0, alive};
            flip  = 8'h00;
            if (r < 70) begin
                // well-formed, next counter
            end else if (r < 76) begin
                if ($urandom_range(0, 1) == 0) ign = 8'($urandom_range(2, 255));
                else gear = 8'($urandom_range(3, 255));
            end else if (r < 81) begin
                b6 = {4'd0, 4'(alive + 4'($urandom_range(1, 14)))};
            end else if (r < 86) begin
                flip = 8'($urandom_range(1, 255));
            end else if (r < 90) begin
                b6[7:4] = 4'($urandom_range(1, 15));
            end else if (r < 94) begin
                len = 4'($urandom_range(0, 14));
                if (len == DLC_FRAME) len = 4'd15;
            end
            if (r < 94) begin
                f = make_frame(len, 16'($urandom), 16'($urandom), ign, gear, b6, flip);
            end else begin
                noise = {$urandom, $urandom, $urandom};
                f = noise[67:0];
            end
            queue_frame(f, i == 0 || i == 1200);
        end
        total_frames = frames_to_send.size();

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        while (in_count < total_frames || want_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
